// ===== src/approx_ripple_adder_alu_core_assert.svh =====
// ----------------------------------------------------------------------------
// approx_ripple_adder_alu_core_assert.svh
// Assertion macros for the approximate ripple-carry ALU.
// ----------------------------------------------------------------------------
`ifndef APPROX_RIPPLE_ADDER_ALU_CORE_ASSERT_SVH
`define APPROX_RIPPLE_ADDER_ALU_CORE_ASSERT_SVH

// antecedent holds, consequent holds in the same cycle
`define ARAD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent holds, consequent holds in the next cycle
`define ARAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/arad_pkg.sv =====
// ----------------------------------------------------------------------------
// arad_pkg
// Types, constants and the full-adder cell for the approximate ripple ALU.
// ----------------------------------------------------------------------------
package arad_pkg;

  localparam int OPERAND_W = 16;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_GE  = 2'd2,
    MODE_LE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CELL_EXACT  = 3'd0,
    CELL_SMA    = 3'd1,
    CELL_AMA1   = 3'd2,
    CELL_AMA2   = 3'd3,
    CELL_AXA2   = 3'd4,
    CELL_AXA3   = 3'd5,
    CELL_BUFFER = 3'd6
  } cell_kind_t;

  // returns {carry, sum}
  function automatic logic [1:0] cell_eval(input logic [2:0] kind, input logic a,
                                           input logic b, input logic c);
    logic s;
    logic co;
    begin
      case (kind)
        CELL_SMA: begin
          co = b | (a & c);
          s  = c & ~(a ^ b);
        end
        CELL_AMA1: begin
          co = b | (a & c);
          s  = ~co;
        end
        CELL_AMA2: begin
          s  = c & (~a | b);
          co = a;
        end
        CELL_AXA2: begin
          s  = ~(a ^ b);
          co = (a & b) | (c & (a ^ b));
        end
        CELL_AXA3: begin
          s  = c & ~(a ^ b);
          co = (a & b) | (c & (a ^ b));
        end
        CELL_BUFFER: begin
          s  = a;
          co = b;
        end
        default: begin
          s  = a ^ b ^ c;
          co = (a & b) | (c & (a ^ b));
        end
      endcase
      return {co, s};
    end
  endfunction

endpackage

// ===== src/approx_ripple_adder_alu_core.sv =====
// ----------------------------------------------------------------------------
// approx_ripple_adder_alu_core
// Ripple-carry add, subtract and compare built from a selectable
// exact or approximate full-adder cell.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | mode, operand_a, operand_b
//  out     | output    | out_valid / out_ready| result
//  cfg     | input     | cfg_valid / cfg_ready| cell_kind
//
//  One request per cycle unless the result stalls, through input register,
//  ripple chain and result register. The WIDTH-cell chain sets the clock.
//  Synchronous reset clears valids and selects the exact cell.
//  A stalled result holds; the input register keeps taking requests
//  while a held result waits, until both stages are full.
// ----------------------------------------------------------------------------
`include "approx_ripple_adder_alu_core_assert.svh"

module approx_ripple_adder_alu_core #(
  parameter int WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     mode,
  input  logic [arad_pkg::OPERAND_W-1:0] operand_a,
  input  logic [arad_pkg::OPERAND_W-1:0] operand_b,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [arad_pkg::OPERAND_W-1:0] result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [2:0]                     cell_kind
);
  import arad_pkg::*;

  localparam int EXT_W = (WIDTH > OPERAND_W) ? WIDTH : OPERAND_W;

  logic [2:0]           kind;
  logic                 s1_valid;
  logic [1:0]           s1_mode;
  logic [OPERAND_W-1:0] s1_a;
  logic [OPERAND_W-1:0] s1_b;
  logic                 s2_adv;

  logic [EXT_W-1:0]     a_ext;
  logic [EXT_W-1:0]     b_ext;
  logic [EXT_W-1:0]     sum_ext;
  logic [WIDTH-1:0]     px;
  logic [WIDTH-1:0]     py;
  logic [WIDTH-1:0]     sum;
  logic                 cin;
  logic                 carry;
  logic [1:0]           cell_out;
  logic [OPERAND_W-1:0] result_next;

  assign cfg_ready = 1'b1;
  assign s2_adv    = !out_valid || out_ready;
  assign in_ready  = !s1_valid || s2_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= CELL_EXACT;
    end else if (cfg_valid && cfg_ready) begin
      kind <= cell_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode <= mode;
      s1_a    <= operand_a;
      s1_b    <= operand_b;
    end
  end

  always_comb begin
    a_ext = EXT_W'(s1_a);
    b_ext = EXT_W'(s1_b);
    case (s1_mode)
      MODE_ADD: begin
        px  = a_ext[WIDTH-1:0];
        py  = b_ext[WIDTH-1:0];
        cin = 1'b0;
      end
      MODE_SUB, MODE_GE: begin
        px  = a_ext[WIDTH-1:0];
        py  = ~b_ext[WIDTH-1:0];
        cin = 1'b1;
      end
      default: begin
        px  = b_ext[WIDTH-1:0];
        py  = ~a_ext[WIDTH-1:0];
        cin = 1'b1;
      end
    endcase
    carry = cin;
    sum   = '0;
    for (int i = 0; i < WIDTH; i++) begin
      cell_out = cell_eval(kind, px[i], py[i], carry);
      sum[i]   = cell_out[0];
      carry    = cell_out[1];
    end
    sum_ext = EXT_W'(sum);
    if (s1_mode == MODE_ADD || s1_mode == MODE_SUB) begin
      result_next = sum_ext[OPERAND_W-1:0];
    end else begin
      result_next = OPERAND_W'(!sum[WIDTH-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_adv) begin
      result <= result_next;
    end
  end

  `ARAD_ASSERT_NEXT(a_accept_loads, clk, rst, in_valid && in_ready, s1_valid)
  `ARAD_ASSERT_NEXT(a_stall_holds, clk, rst, s1_valid && !s2_adv,
                    s1_valid && $stable(s1_a) && $stable(s1_b) && $stable(s1_mode))
  `ARAD_ASSERT_NEXT(a_cmp_boolean, clk, rst,
                    s1_valid && s2_adv && (s1_mode == MODE_GE || s1_mode == MODE_LE),
                    out_valid && result[OPERAND_W-1:1] == '0)

endmodule
